FILE: sv/ahxd_pkg.sv
// shared types, codes and constants for the archive header xor decryptor
// no dependencies; imported by every module of the block
package ahxd_pkg;

   localparam int MAX_NAME_LENGTH_DEF = 256;
   localparam int HEADER_BYTES_DEF    = 8;

   localparam int KEY_W   = 32;
   localparam int INDEX_W = 24;
   localparam int LIMIT_W = 25;
   localparam int CSR_AW  = 3;

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_INITIAL_KEY = 1'b0;
   localparam logic CSR_IDX_MAX_FILES   = 1'b1;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LEN,
      PH_NAME,
      PH_SIZE,
      PH_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NAME  = 2'd0,
      KIND_HDR   = 2'd1,
      KIND_DATA  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           out_value;
      logic [KEY_W-1:0]     file_size;
      logic [KEY_W-1:0]     data_key;
      logic [INDEX_W-1:0]   entry_index;
      logic                 last;
   } res_type;

   // keystream step: key*7 + 3 mod 2^32
   function automatic logic [KEY_W-1:0] key_next(input logic [KEY_W-1:0] k);
      key_next = (k << 3) - k + KEY_W'(3);
   endfunction

endpackage

FILE: sv/ahxd_core.sv
// entry parser and keystream: phase, counters, key; one byte per accepted word
// depends on ahxd_pkg
module ahxd_core import ahxd_pkg::*; #(
   parameter int MAX_NAME_LENGTH = MAX_NAME_LENGTH_DEF,
   parameter int HEADER_BYTES    = HEADER_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_fire,
   input  logic [7:0]         in_byte,
   input  logic               in_start,
   input  logic [KEY_W-1:0]   initial_key,
   input  logic [LIMIT_W-1:0] max_files,
   output logic               res_valid,
   output res_type            res
);

   localparam phase_type FIRST_PHASE = (HEADER_BYTES > 0) ? PH_HEADER : PH_LEN;

   phase_type            phase_ff, phase_in;
   logic [31:0]          count_ff, count_in;
   logic [23:0]          gather_ff, gather_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [INDEX_W-1:0]   files_ff, files_in;

   phase_type            cur_phase;
   logic [31:0]          cur_count, count_inc, count_dec;
   logic [23:0]          cur_gather;
   logic [KEY_W-1:0]     cur_key, key_step, word;
   logic [INDEX_W-1:0]   cur_files, files_inc;
   logic                 limit_hit;

   always_comb begin
      // archive start acts as a reset of the parse state for this byte
      cur_phase  = in_start ? FIRST_PHASE : phase_ff;
      cur_count  = in_start ? 32'd0 : count_ff;
      cur_gather = in_start ? 24'd0 : gather_ff;
      cur_key    = in_start ? initial_key : key_ff;
      cur_files  = in_start ? '0 : files_ff;

      count_inc = cur_count + 32'd1;
      count_dec = (cur_count != 32'd0) ? cur_count - 32'd1 : 32'd0;
      key_step  = key_next(cur_key);
      word      = {in_byte, cur_gather} ^ cur_key;
      files_inc = cur_files + INDEX_W'(1);
      limit_hit = !max_files[LIMIT_W-1] && (files_inc > max_files[INDEX_W-1:0]);

      phase_in  = cur_phase;
      count_in  = cur_count;
      gather_in = cur_gather;
      key_in    = cur_key;
      files_in  = cur_files;

      res_valid       = 1'b0;
      res.kind        = KIND_NAME;
      res.out_value   = 8'd0;
      res.file_size   = '0;
      res.data_key    = '0;
      res.entry_index = cur_files;
      res.last        = 1'b0;

      case (cur_phase)
         PH_HEADER: begin
            if (count_inc >= 32'(HEADER_BYTES)) begin
               phase_in = PH_LEN;
               count_in = 32'd0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_LEN, PH_SIZE: begin
            if (cur_count[1:0] != 2'd3) begin
               count_in = count_inc;
               case (cur_count[1:0])
                  2'd0:    gather_in[7:0]   = in_byte;
                  2'd1:    gather_in[15:8]  = in_byte;
                  default: gather_in[23:16] = in_byte;
               endcase
            end else begin
               key_in    = key_step;
               gather_in = 24'd0;
               count_in  = 32'd0;
               if (cur_phase == PH_LEN) begin
                  if (word > 32'(MAX_NAME_LENGTH)) begin
                     phase_in  = PH_ERROR;
                     res_valid = 1'b1;
                     res.kind  = KIND_ERROR;
                  end else if (word == 32'd0) begin
                     phase_in = PH_SIZE;
                  end else begin
                     phase_in = PH_NAME;
                     count_in = word;
                  end
               end else begin
                  res_valid     = 1'b1;
                  res.kind      = KIND_HDR;
                  res.file_size = word;
                  res.data_key  = key_step;
                  if (word == 32'd0) begin
                     files_in = files_inc;
                     phase_in = limit_hit ? PH_DONE : PH_LEN;
                  end else begin
                     phase_in = PH_DATA;
                     count_in = word;
                  end
               end
            end
         end
         PH_NAME: begin
            res_valid     = 1'b1;
            res.kind      = KIND_NAME;
            res.out_value = in_byte ^ cur_key[7:0];
            key_in        = key_step;
            count_in      = count_dec;
            if (count_dec == 32'd0) begin
               res.last  = 1'b1;
               phase_in  = PH_SIZE;
               gather_in = 24'd0;
            end
         end
         PH_DATA: begin
            res_valid     = 1'b1;
            res.kind      = KIND_DATA;
            res.out_value = in_byte;
            count_in      = count_dec;
            if (count_dec == 32'd0) begin
               res.last  = 1'b1;
               files_in  = files_inc;
               phase_in  = limit_hit ? PH_DONE : PH_LEN;
               gather_in = 24'd0;
            end
         end
         default: begin
         end
      endcase

      if (!in_fire) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= FIRST_PHASE;
         count_ff  <= 32'd0;
         gather_ff <= 24'd0;
         key_ff    <= '0;
         files_ff  <= '0;
      end else if (in_fire) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         gather_ff <= gather_in;
         key_ff    <= key_in;
         files_ff  <= files_in;
      end
   end

endmodule

FILE: sv/ahxd_out_buf.sv
// two-entry result buffer between the parser and the result channel
// depends on ahxd_pkg
module ahxd_out_buf import ahxd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  res_type push_res,
   output logic    space,
   output logic    out_valid,
   input  logic    out_ready,
   output res_type out_res
);

   res_type     slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        pop;

   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_res   = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

FILE: sv/archive_header_xor_decryptor.sv
// top level of the archive header xor decryptor: csr registers, parser, result buffer
// depends on ahxd_pkg, ahxd_core, ahxd_out_buf
//
//   channel  | direction | payload
//   req_     | in        | tdata: data_byte; tuser: archive_start
//   rsp_     | out       | tdata: out_value, file_size, data_key, entry_index;
//            |           | tuser: kind; tlast: last
//   csr_     | apb       | 0x0 initial_key, 0x4 max_files (25-bit signed)
//
// the parser updates its state in the cycle the word is taken
// and the result is in the buffer register the next cycle
// a word is taken every cycle while the two-entry result buffer has room
// reset is synchronous and returns to header skip (length word if HEADER_BYTES is 0) with a zero key
// a stalled rsp_ side fills the buffer, then req_tready drops
module archive_header_xor_decryptor import ahxd_pkg::*; #(
   parameter int MAX_NAME_LENGTH = MAX_NAME_LENGTH_DEF,
   parameter int HEADER_BYTES    = HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // input stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tuser,   // [0] archive_start
   // result stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [95:0]       rsp_tdata,   // [7:0] out_value, [39:8] file_size,
                                          // [71:40] data_key, [95:72] entry_index
   output logic [1:0]        rsp_tuser,   // [1:0] kind
   output logic              rsp_tlast,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [KEY_W-1:0]   initial_key_ff;
   logic [LIMIT_W-1:0] max_files_ff;
   logic               csr_write;

   logic               req_fire;
   logic               res_valid;
   res_type            res;
   logic               buf_space;
   res_type            out_res;

   // apb: always ready, written at the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_key_ff <= '0;
         max_files_ff   <= '1;   // -1: no entry limit
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_INITIAL_KEY: initial_key_ff <= csr_pwdata;
            CSR_IDX_MAX_FILES:   max_files_ff   <= csr_pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_INITIAL_KEY: csr_prdata = initial_key_ff;
         CSR_IDX_MAX_FILES:   csr_prdata = {{(32-LIMIT_W){1'b0}}, max_files_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // parser never stalls; only buffer room gates the input side
   assign req_tready = buf_space;
   assign req_fire   = req_tvalid && req_tready;

   ahxd_core #(
      .MAX_NAME_LENGTH (MAX_NAME_LENGTH),
      .HEADER_BYTES    (HEADER_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (req_fire),
      .in_byte     (req_tdata),
      .in_start    (req_tuser),
      .initial_key (initial_key_ff),
      .max_files   (max_files_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   ahxd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_res  (res),
      .space     (buf_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   // result word packing, highest field listed first, out_value in the lowest bits
   assign rsp_tdata = {out_res.entry_index, out_res.data_key,
                       out_res.file_size, out_res.out_value};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

   // a result only comes from an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> req_fire)
      else $error("result without an accepted input word");

   // the first byte of an archive is always a header byte when a header exists
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser && (HEADER_BYTES > 0)) |-> !res_valid)
      else $error("result on the first header byte");

   // size and key are only carried by the entry header word
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind != KIND_HDR) |-> (res.file_size == '0 && res.data_key == '0))
      else $error("size or key on a non-header result");

   // never push into a full buffer
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> buf_space)
      else $error("result buffer overflow");

endmodule

FILE: tb/tb_archive_header_xor_decryptor.sv
// testbench for archive_header_xor_decryptor: directed byte table, then random archives
// checked word by word against an in-bench decryptor model; depends on ahxd_pkg
module tb_archive_header_xor_decryptor;
   import ahxd_pkg::*;

   localparam int STALL_LIMIT  = 1000;  // cycles with no word moving anywhere
   localparam int PHASE_WORDS  = 215;   // random input words per register setting
   localparam int SETTLE_TICKS = 4;     // drain time after the last result

   // one row of the directed table: input word, and optionally a hand-written result
   typedef struct packed {
      logic [7:0] b;
      logic       s;
      bit         typed;
      res_type    want;
   } stim_row_type;

   // default registers: key 0, no entry limit
   // header, then an entry with empty name and empty file, then a one-char name
   // with one data byte, then a length of all ones that trips the error
   localparam stim_row_type DIRECTED_ROWS [30] = '{
      '{8'hFF, 1'b1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h5A, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hA5, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      // name length 0 under key 0
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      // size 0 under key 3, next key 24
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{KIND_HDR, 8'h00, 32'd0, 32'd24, 24'd0, 1'b0}},
      // name length 1 under key 24
      '{8'h19, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      // 'A' under key low byte 0xab
      '{8'hEA, 1'b0, 1'b1, '{KIND_NAME, 8'h41, 32'd0, 32'd0, 24'd1, 1'b1}},
      // size 1 under key 0x4b0, next key 0x20d3
      '{8'hB1, 1'b0, 1'b0, '0},
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{KIND_HDR, 8'h00, 32'd1, 32'h20D3, 24'd1, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{KIND_DATA, 8'h00, 32'd0, 32'd0, 24'd1, 1'b1}},
      // length 0xffffffff under key 0x20d3
      '{8'h2C, 1'b0, 1'b0, '0},
      '{8'hDF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{KIND_ERROR, 8'h00, 32'd0, 32'd0, 24'd2, 1'b0}}
   };

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata   = 8'h00;   // [7:0] data_byte
   logic              req_tuser   = 1'b0;    // [0] archive_start
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [95:0]       rsp_tdata;             // [7:0] out_value, [39:8] file_size,
                                             // [71:40] data_key, [95:72] entry_index
   logic [1:0]        rsp_tuser;             // [1:0] kind
   logic              rsp_tlast;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // idle percentages for the two sides
   int send_idle_pct = 12;
   int recv_idle_pct = 61;

   int fail_count  = 0;
   int items_sent  = 0;
   int stall_ticks = 0;

   // results still owed by the block, oldest first
   res_type pending_results [$];

   // decryptor model state, reset values
   phase_type          ph_now       = (HEADER_BYTES_DEF > 0) ? PH_HEADER : PH_LEN;
   logic [31:0]        pos_count    = '0;
   logic [31:0]        word_acc     = '0;
   logic [KEY_W-1:0]   cipher_key   = '0;
   logic [INDEX_W-1:0] entry_count  = '0;
   logic               err_seen     = 1'b0;
   logic [KEY_W-1:0]   cfg_init_key = '0;
   int                 cfg_max_files = -1;

   archive_header_xor_decryptor u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // entry done: bump the count, stop once past the limit
   function automatic void close_entry();
      entry_count = entry_count + 1'b1;
      if (cfg_max_files >= 0 && int'({8'd0, entry_count}) > cfg_max_files)
         ph_now = PH_DONE;
      else
         ph_now = PH_LEN;
      pos_count = '0;
      word_acc  = '0;
   endfunction

   // advance the decryptor by one archive byte; returns 1 when a result is due
   function automatic bit decrypt_byte(input logic [7:0] b, input logic s,
                                       output res_type r);
      logic [31:0] word;
      if (s) begin
         cipher_key  = cfg_init_key;
         pos_count   = '0;
         word_acc    = '0;
         entry_count = '0;
         err_seen    = 1'b0;
         ph_now      = (HEADER_BYTES_DEF > 0) ? PH_HEADER : PH_LEN;
      end
      r = '0;
      r.kind = KIND_NAME;
      r.entry_index = entry_count;
      case (ph_now)
         PH_HEADER: begin
            pos_count = pos_count + 1;
            if (pos_count >= HEADER_BYTES_DEF) begin
               ph_now    = PH_LEN;
               pos_count = '0;
            end
            return 1'b0;
         end
         PH_LEN, PH_SIZE: begin
            // little-endian gather, then xor with the whole key
            word_acc  = word_acc | (32'(b) << (8 * pos_count[1:0]));
            pos_count = pos_count + 1;
            if (pos_count < 4) return 1'b0;
            word       = word_acc ^ cipher_key;
            cipher_key = cipher_key * 32'd7 + 32'd3;
            word_acc   = '0;
            pos_count  = '0;
            if (ph_now == PH_LEN) begin
               if (word > MAX_NAME_LENGTH_DEF) begin
                  err_seen = 1'b1;
                  ph_now   = PH_ERROR;
                  r.kind   = KIND_ERROR;
                  return 1'b1;
               end
               if (word == 0) ph_now = PH_SIZE;
               else begin
                  ph_now    = PH_NAME;
                  pos_count = word;
               end
               return 1'b0;
            end
            r.kind      = KIND_HDR;
            r.file_size = word;
            r.data_key  = cipher_key;
            if (word == 0) close_entry();
            else begin
               ph_now    = PH_DATA;
               pos_count = word;
            end
            return 1'b1;
         end
         PH_NAME: begin
            // name chars use only the low key byte, key steps per char
            r.out_value = b ^ cipher_key[7:0];
            cipher_key  = cipher_key * 32'd7 + 32'd3;
            if (pos_count > 0) pos_count = pos_count - 1;
            if (pos_count == 0) begin
               r.last   = 1'b1;
               ph_now   = PH_SIZE;
               word_acc = '0;
            end
            return 1'b1;
         end
         PH_DATA: begin
            r.kind      = KIND_DATA;
            r.out_value = b;
            if (pos_count > 0) pos_count = pos_count - 1;
            if (pos_count == 0) begin
               r.last = 1'b1;
               close_entry();
            end
            return 1'b1;
         end
         default: return 1'b0;  // stopped by the limit or by an error
      endcase
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch %s: got %h, want %h", field, got, want);
      fail_count++;
   endtask

   // send one byte; called at a falling edge, returns at the falling edge after acceptance
   task automatic push_byte(input logic [7:0] b, input logic s, input bit typed,
                            input res_type want);
      res_type got;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= s;
      do @(posedge clock); while (!req_tready);
      // ignored bytes after a stop do not count toward the budget
      if (s || !(ph_now inside {PH_DONE, PH_ERROR})) items_sent++;
      if (decrypt_byte(b, s, got)) pending_results.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   // encrypt a plain word with the current key and send it low byte first
   task automatic send_word(input logic [31:0] plain);
      logic [31:0] enc;
      enc = plain ^ cipher_key;
      for (int i = 0; i < 4; i++) push_byte(enc[8*i +: 8], 1'b0, 1'b0, '0);
   endtask

   task automatic push_noise(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) push_byte(8'($urandom), 1'b0, 1'b0, '0);
   endtask

   // one random archive, mostly well formed, sometimes cut short
   task automatic run_archive();
      int n_hdr;
      int n_entries;
      int pick;
      logic [31:0] name_len;
      logic [31:0] file_len;
      // now and then a new archive starts inside the header
      n_hdr = ($urandom_range(0, 14) == 0) ? $urandom_range(1, HEADER_BYTES_DEF - 1)
                                           : HEADER_BYTES_DEF;
      for (int i = 0; i < n_hdr; i++) push_byte(8'($urandom), i == 0, 1'b0, '0);
      if (n_hdr < HEADER_BYTES_DEF) return;
      n_entries = $urandom_range(1, 6);
      for (int e = 0; e < n_entries; e++) begin
         // broken sequence: cut off inside the length word
         if ($urandom_range(0, 24) == 0) begin
            push_noise(1, 3);
            return;
         end
         pick = $urandom_range(0, 99);
         if (pick < 12)      name_len = 32'd0;
         else if (pick < 13) name_len = 32'(MAX_NAME_LENGTH_DEF);
         else if (pick < 14) name_len = 32'(MAX_NAME_LENGTH_DEF + 1);
         else if (pick < 15) name_len = 32'hFFFF_FFFF;
         else if (pick < 17) name_len = $urandom | 32'h0000_0200;
         else                name_len = 32'($urandom_range(1, 12));
         send_word(name_len);
         if (ph_now == PH_ERROR) begin
            // error is sticky, everything after it is dropped
            push_noise(1, 4);
            return;
         end
         repeat (name_len) push_byte(8'($urandom), 1'b0, 1'b0, '0);
         pick = $urandom_range(0, 99);
         if (pick < 15)      file_len = 32'd0;
         else if (pick < 17) file_len = 32'hFFFF_FFFF;
         else                file_len = 32'($urandom_range(1, 16));
         send_word(file_len);
         if (file_len == 32'hFFFF_FFFF) begin
            // endless file, abandoned by the next archive start
            push_noise(1, 5);
            return;
         end
         repeat (file_len) push_byte(8'($urandom), 1'b0, 1'b0, '0);
         if (ph_now == PH_DONE) begin
            push_noise(1, 3);
            return;
         end
      end
   endtask

   // apb write: setup cycle, then access cycle
   task automatic csr_write(input logic idx, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_IDX_INITIAL_KEY) cfg_init_key = v;
      else cfg_max_files = int'($signed(v[LIMIT_W-1:0]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // stop sending, wait for every owed word, then let the pipe drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // result checker: every word against the oldest expectation
   always @(posedge clock) begin : result_check
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("unexpected word, kind", 32'(rsp_tuser), 32'hx);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind)
               flag_mismatch("kind", 32'(rsp_tuser), 32'(want.kind));
            if (rsp_tdata[7:0] !== want.out_value)
               flag_mismatch("out_value", 32'(rsp_tdata[7:0]), 32'(want.out_value));
            if (rsp_tdata[39:8] !== want.file_size)
               flag_mismatch("file_size", rsp_tdata[39:8], want.file_size);
            if (rsp_tdata[71:40] !== want.data_key)
               flag_mismatch("data_key", rsp_tdata[71:40], want.data_key);
            if (rsp_tdata[95:72] !== want.entry_index)
               flag_mismatch("entry_index", 32'(rsp_tdata[95:72]), 32'(want.entry_index));
            if (rsp_tlast !== want.last)
               flag_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_ticks <= 0;
      else
         stall_ticks <= stall_ticks + 1;
      if (stall_ticks >= STALL_LIMIT) begin
         $display("timeout, %0d results still owed", pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0]        key_setting;
      logic [LIMIT_W-1:0] limit_setting;
      int                 goal;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table under reset register values
      foreach (DIRECTED_ROWS[r])
         push_byte(DIRECTED_ROWS[r].b, DIRECTED_ROWS[r].s, DIRECTED_ROWS[r].typed,
                   DIRECTED_ROWS[r].want);
      settle();

      // random archives under several register settings and idle mixes
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               key_setting   = 32'hFFFF_FFFF;
               limit_setting = 25'h1FF_FFFF;   // -1, unlimited
            end
            1: begin
               key_setting   = $urandom;
               limit_setting = 25'd0;          // stop after the first entry
            end
            2: begin
               key_setting   = 32'h0000_0000;
               limit_setting = 25'h0FF_FFFF;   // largest positive limit
            end
            3: begin
               key_setting   = $urandom;
               limit_setting = 25'd2;
            end
            4: begin
               key_setting   = $urandom;
               limit_setting = 25'h100_0000;   // most negative, still unlimited
            end
            default: begin
               key_setting   = 32'h8000_0001;
               limit_setting = 25'd1;
            end
         endcase
         // sender light and receiver heavy, then swapped, then no idling
         if (p < 2) begin
            send_idle_pct = 12;
            recv_idle_pct = 61;
         end else if (p < 4) begin
            send_idle_pct = 61;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         csr_write(CSR_IDX_INITIAL_KEY, key_setting);
         csr_write(CSR_IDX_MAX_FILES, 32'(limit_setting));
         goal = items_sent + PHASE_WORDS;
         while (items_sent < goal) run_archive();
         settle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: archive_header_xor_decryptor.f
sv/ahxd_pkg.sv
sv/ahxd_core.sv
sv/ahxd_out_buf.sv
sv/archive_header_xor_decryptor.sv
tb/tb_archive_header_xor_decryptor.sv
